/* src/cntm_pkg.sv */
package cntm_pkg;

  localparam int unsigned PosW  = 16;
  localparam int unsigned BoxW  = 12;
  localparam int unsigned AreaW = 24;
  localparam int unsigned IdW   = 32;
  localparam int unsigned CntW  = 4;
  localparam int unsigned Thr2W = 24;

  localparam logic [7:0] ThrDefault = 8'd50;
  localparam logic [7:0] ThrMin     = 8'd10;
  localparam logic [7:0] ThrMax     = 8'd150;
  localparam logic [3:0] LostDefault = 4'd5;
  localparam logic [3:0] LostMax     = 4'd10;
  localparam logic [15:0] AreaDefault = 16'd25;

  typedef enum logic [1:0] {
    REG_DIST_THR = 2'd0,
    REG_MAX_LOST = 2'd1,
    REG_MIN_AREA = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [BoxW-1:0] left;
    logic [BoxW-1:0] top;
    logic [BoxW-1:0] width;
    logic [BoxW-1:0] height;
  } det_t;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [BoxW-1:0] left;
    logic [BoxW-1:0] top;
    logic [BoxW-1:0] width;
    logic [BoxW-1:0] height;
    logic [CntW-1:0] life;
    logic [CntW-1:0] lost;
  } trk_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_CHK,
    ST_D_RD,
    ST_D_MUL,
    ST_D_CMP,
    ST_T_DONE,
    ST_T_MATCH,
    ST_N_RD,
    ST_N_WR,
    ST_FIN,
    ST_E_RD,
    ST_E_LD
  } state_e;

  typedef struct packed {
    logic load;
    logic frm_start;
    logic k_clr;
    logic k_inc;
    logic i_clr;
    logic i_inc;
    logic best_init;
    logic trk_rd;
    logic det_rd;
    logic det_rd_pick;
    logic sq_en;
    logic cmp_en;
    logic wr_match;
    logic wr_keep;
    logic wr_new;
    logic set_drop;
    logic fin;
    logic out_load;
    logic drop_clr;
  } cmd_t;

  typedef struct packed {
    logic k_end;
    logic i_end;
    logic claimed_i;
    logic pick_ok;
    logic keep_ok;
    logic trk_full;
    logic n_zero;
    logic k_last;
    logic out_busy;
  } sts_t;

  function automatic logic [7:0] eff_thr(input logic [7:0] raw);
    logic [7:0] t;
    t = (raw == 8'd0) ? ThrDefault : raw;
    if (t < ThrMin) t = ThrMin;
    if (t > ThrMax) t = ThrMax;
    return t;
  endfunction

  function automatic logic [3:0] eff_lost(input logic [3:0] raw);
    logic [3:0] m;
    m = (raw == 4'd0) ? LostDefault : raw;
    if (m > LostMax) m = LostMax;
    return m;
  endfunction

endpackage

/* src/cntm_ctrl.sv */
module cntm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            s_last_i,
  output logic            s_ready_o,
  input  cntm_pkg::sts_t  sts_i,
  output cntm_pkg::cmd_t  cmd_o
);

  cntm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cntm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      cntm_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          if (s_last_i) begin
            cmd_o.frm_start = 1'b1;
            state_d = cntm_pkg::ST_T_CHK;
          end
        end
      end
      cntm_pkg::ST_T_CHK: begin
        cmd_o.i_clr = 1'b1;
        if (sts_i.k_end) begin
          state_d = cntm_pkg::ST_N_RD;
        end else begin
          cmd_o.trk_rd    = 1'b1;
          cmd_o.best_init = 1'b1;
          state_d = cntm_pkg::ST_D_RD;
        end
      end
      cntm_pkg::ST_D_RD: begin
        priority if (sts_i.i_end) begin
          state_d = cntm_pkg::ST_T_DONE;
        end else if (sts_i.claimed_i) begin
          cmd_o.i_inc = 1'b1;
        end else begin
          cmd_o.det_rd = 1'b1;
          state_d = cntm_pkg::ST_D_MUL;
        end
      end
      cntm_pkg::ST_D_MUL: begin
        cmd_o.sq_en = 1'b1;
        state_d = cntm_pkg::ST_D_CMP;
      end
      cntm_pkg::ST_D_CMP: begin
        cmd_o.cmp_en = 1'b1;
        cmd_o.i_inc  = 1'b1;
        state_d = cntm_pkg::ST_D_RD;
      end
      cntm_pkg::ST_T_DONE: begin
        priority if (sts_i.pick_ok) begin
          cmd_o.det_rd_pick = 1'b1;
          state_d = cntm_pkg::ST_T_MATCH;
        end else if (sts_i.keep_ok) begin
          cmd_o.wr_keep = 1'b1;
          cmd_o.k_inc   = 1'b1;
          state_d = cntm_pkg::ST_T_CHK;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d = cntm_pkg::ST_T_CHK;
        end
      end
      cntm_pkg::ST_T_MATCH: begin
        cmd_o.wr_match = 1'b1;
        cmd_o.k_inc    = 1'b1;
        state_d = cntm_pkg::ST_T_CHK;
      end
      cntm_pkg::ST_N_RD: begin
        priority if (sts_i.i_end) begin
          state_d = cntm_pkg::ST_FIN;
        end else if (sts_i.claimed_i) begin
          cmd_o.i_inc = 1'b1;
        end else if (sts_i.trk_full) begin
          cmd_o.set_drop = 1'b1;
          cmd_o.i_inc    = 1'b1;
        end else begin
          cmd_o.det_rd = 1'b1;
          state_d = cntm_pkg::ST_N_WR;
        end
      end
      cntm_pkg::ST_N_WR: begin
        cmd_o.wr_new = 1'b1;
        cmd_o.i_inc  = 1'b1;
        state_d = cntm_pkg::ST_N_RD;
      end
      cntm_pkg::ST_FIN: begin
        cmd_o.fin   = 1'b1;
        cmd_o.k_clr = 1'b1;
        if (sts_i.n_zero) begin
          cmd_o.drop_clr = 1'b1;
          state_d = cntm_pkg::ST_IDLE;
        end else begin
          state_d = cntm_pkg::ST_E_RD;
        end
      end
      cntm_pkg::ST_E_RD: begin
        cmd_o.trk_rd = 1'b1;
        state_d = cntm_pkg::ST_E_LD;
      end
      cntm_pkg::ST_E_LD: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.k_inc    = 1'b1;
          if (sts_i.k_last) begin
            cmd_o.drop_clr = 1'b1;
            state_d = cntm_pkg::ST_IDLE;
          end else begin
            state_d = cntm_pkg::ST_E_RD;
          end
        end
      end
      default: state_d = cntm_pkg::ST_IDLE;
    endcase
  end

endmodule

/* src/cntm_dpath.sv */
module cntm_dpath #(
  parameter int unsigned MAX_TRACKS     = 32,
  parameter int unsigned MAX_DETECTIONS = 32,
  parameter int unsigned LIFETIME_CAP   = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cntm_pkg::cmd_t                   cmd_i,
  output cntm_pkg::sts_t                   sts_o,
  input  cntm_pkg::det_t                   det_i,
  input  logic [cntm_pkg::AreaW-1:0]       area_i,
  input  logic [15:0]                      min_area_i,
  input  logic [cntm_pkg::Thr2W-1:0]       thr2_i,
  input  logic [cntm_pkg::CntW-1:0]        lost_lim_i,
  input  logic                             m_ready_i,
  output logic                             out_valid_o,
  output cntm_pkg::trk_t                   out_trk_o,
  output logic                             out_last_o,
  output logic                             out_ovf_o
);

  localparam int unsigned TCW = $clog2(MAX_TRACKS + 1);
  localparam int unsigned TIW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned DCW = $clog2(MAX_DETECTIONS + 1);
  localparam int unsigned DIW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;

  cntm_pkg::trk_t trk_mem [MAX_TRACKS];
  cntm_pkg::det_t det_mem [MAX_DETECTIONS];

  logic [TCW-1:0]            k_q, n_q, trk_n_q;
  logic [DCW-1:0]            i_q, det_cnt_q;
  logic [DIW-1:0]            pick_q;
  logic                      pick_vld_q;
  logic [32:0]               best_q;
  logic [31:0]               sqx_q, sqy_q;
  logic [MAX_DETECTIONS-1:0] claimed_q;
  logic                      drop_q;
  logic [31:0]               next_id_q;
  cntm_pkg::trk_t            trk_rd_q, trk_wdata;
  cntm_pkg::det_t            det_rd_q;
  logic                      out_valid_q;

  logic          keep_det, det_full, det_wr, wr_any;
  logic [15:0]   dx, dy;
  logic [32:0]   dsum;
  logic [DIW-1:0] det_raddr;

  assign keep_det = (area_i != '0) && (area_i >= {8'b0, min_area_i});
  assign det_full = (det_cnt_q == DCW'(MAX_DETECTIONS));
  assign det_wr   = cmd_i.load && keep_det && !det_full;
  assign wr_any   = cmd_i.wr_match || cmd_i.wr_keep || cmd_i.wr_new;
  assign det_raddr = cmd_i.det_rd_pick ? pick_q : i_q[DIW-1:0];

  assign dx = (trk_rd_q.x > det_rd_q.x) ? (trk_rd_q.x - det_rd_q.x) : (det_rd_q.x - trk_rd_q.x);
  assign dy = (trk_rd_q.y > det_rd_q.y) ? (trk_rd_q.y - det_rd_q.y) : (det_rd_q.y - trk_rd_q.y);
  assign dsum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    trk_wdata = trk_rd_q;
    priority if (cmd_i.wr_new) begin
      trk_wdata.id     = next_id_q;
      trk_wdata.x      = det_rd_q.x;
      trk_wdata.y      = det_rd_q.y;
      trk_wdata.left   = det_rd_q.left;
      trk_wdata.top    = det_rd_q.top;
      trk_wdata.width  = det_rd_q.width;
      trk_wdata.height = det_rd_q.height;
      trk_wdata.life   = '0;
      trk_wdata.lost   = '0;
    end else if (cmd_i.wr_match) begin
      trk_wdata.x      = det_rd_q.x;
      trk_wdata.y      = det_rd_q.y;
      trk_wdata.left   = det_rd_q.left;
      trk_wdata.top    = det_rd_q.top;
      trk_wdata.width  = det_rd_q.width;
      trk_wdata.height = det_rd_q.height;
      trk_wdata.life   = (trk_rd_q.life < 4'(LIFETIME_CAP)) ? trk_rd_q.life + 4'd1
                                                            : trk_rd_q.life;
      trk_wdata.lost   = '0;
    end else begin
      trk_wdata.life = '0;
      trk_wdata.lost = trk_rd_q.lost + 4'd1;
    end
  end

  // Survivors are compacted in place: the write slot never passes the read slot.
  always_ff @(posedge clk_i) begin
    if (wr_any) trk_mem[n_q[TIW-1:0]] <= trk_wdata;
    if (cmd_i.trk_rd) trk_rd_q <= trk_mem[k_q[TIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (det_wr) det_mem[det_cnt_q[DIW-1:0]] <= det_i;
    if (cmd_i.det_rd || cmd_i.det_rd_pick) det_rd_q <= det_mem[det_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sqx_q <= {16'b0, dx} * {16'b0, dx};
      sqy_q <= {16'b0, dy} * {16'b0, dy};
    end
    if (cmd_i.best_init) begin
      best_q <= {9'b0, thr2_i};
    end else if (cmd_i.cmp_en && (dsum < best_q)) begin
      best_q <= dsum;
      pick_q <= i_q[DIW-1:0];
    end
    if (cmd_i.out_load) begin
      out_trk_o  <= trk_rd_q;
      out_last_o <= ({1'b0, k_q} + 1'b1) == {1'b0, trk_n_q};
      out_ovf_o  <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      n_q         <= '0;
      trk_n_q     <= '0;
      i_q         <= '0;
      det_cnt_q   <= '0;
      pick_vld_q  <= 1'b0;
      claimed_q   <= '0;
      drop_q      <= 1'b0;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.frm_start || cmd_i.k_clr) k_q <= '0;
      else if (cmd_i.k_inc) k_q <= k_q + 1'b1;

      if (cmd_i.frm_start) n_q <= '0;
      else if (wr_any) n_q <= n_q + 1'b1;

      if (cmd_i.i_clr) i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + 1'b1;

      if (cmd_i.fin) det_cnt_q <= '0;
      else if (det_wr) det_cnt_q <= det_cnt_q + 1'b1;

      if (cmd_i.best_init) pick_vld_q <= 1'b0;
      else if (cmd_i.cmp_en && (dsum < best_q)) pick_vld_q <= 1'b1;

      if (cmd_i.fin) claimed_q <= '0;
      else if (cmd_i.wr_match) claimed_q[pick_q] <= 1'b1;

      if ((cmd_i.load && keep_det && det_full) || cmd_i.set_drop) drop_q <= 1'b1;
      else if (cmd_i.drop_clr) drop_q <= 1'b0;

      if (cmd_i.wr_new) next_id_q <= next_id_q + 32'd1;

      if (cmd_i.fin) trk_n_q <= n_q;

      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.k_end     = (k_q == trk_n_q);
  assign sts_o.i_end     = (i_q == det_cnt_q);
  assign sts_o.claimed_i = claimed_q[i_q[DIW-1:0]];
  assign sts_o.pick_ok   = pick_vld_q;
  assign sts_o.keep_ok   = (trk_rd_q.lost < lost_lim_i);
  assign sts_o.trk_full  = (n_q == TCW'(MAX_TRACKS));
  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.k_last    = ({1'b0, k_q} + 1'b1) == {1'b0, trk_n_q};
  assign sts_o.out_busy  = out_valid_q && !m_ready_i;

`ifndef ASSERT_OFF
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_match || cmd_i.wr_keep) |-> (n_q <= k_q))
    else $error("track write slot overtook read slot");

  a_new_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> (n_q < TCW'(MAX_TRACKS)))
    else $error("new track written into a full store");

  a_det_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_cnt_q <= DCW'(MAX_DETECTIONS))
    else $error("detection count beyond store depth");

  a_claim_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_match |-> (pick_vld_q && !claimed_q[pick_q]))
    else $error("detection claimed twice or without a pick");
`endif

endmodule

/* src/centroid_nearest_track_matcher.sv */
// Greedy nearest-neighbour centroid tracker. Detections are taken one word per cycle
// and buffered; a word with tlast ends the frame and starts matching, during which
// s_axis_tready is low. Each stored track scans every buffered detection: an
// unclaimed detection goes through memory read, squaring and compare, a claimed one
// is skipped, and the track is then updated, the sequential distance scan over the
// detection memory being the dominant cost. Results leave through a registered output
// in ascending track order; each is read from the track memory and then loaded into
// the output register once that register is free or being taken by the sink; the last
// result of a frame carries tlast, and tuser flags a frame in which a detection or a
// new track was dropped for lack of space.
module centroid_nearest_track_matcher #(
  parameter int unsigned MAX_TRACKS     = 32,
  parameter int unsigned MAX_DETECTIONS = 32,
  parameter int unsigned LIFETIME_CAP   = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // centroid_x, centroid_y, box_left, box_top, box_width, box_height, area
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // track_id, track_x, track_y, track_left, track_top, track_width,
  // track_height, lifetime, lost_frames, zero fill
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // overflow
  output logic [0:0]   m_axis_tuser
);

  logic [7:0]  thr_q;
  logic [3:0]  lost_q;
  logic [15:0] min_area_q;
  logic [cntm_pkg::Thr2W-1:0] thr2_q;
  logic [11:0] thr16;

  cntm_pkg::cmd_t cmd;
  cntm_pkg::sts_t sts;
  cntm_pkg::det_t det;
  cntm_pkg::trk_t out_trk;
  logic           out_last, out_ovf;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= cntm_pkg::ThrDefault;
      lost_q     <= cntm_pkg::LostDefault;
      min_area_q <= cntm_pkg::AreaDefault;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        cntm_pkg::REG_DIST_THR: thr_q      <= cfg_data_i[7:0];
        cntm_pkg::REG_MAX_LOST: lost_q     <= cfg_data_i[3:0];
        cntm_pkg::REG_MIN_AREA: min_area_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Squared radius in Q12.4 units, i.e. (16 * threshold)^2.
  assign thr16 = {cntm_pkg::eff_thr(thr_q), 4'b0};

  always_ff @(posedge clk_i) begin
    thr2_q <= {12'b0, thr16} * {12'b0, thr16};
  end

  assign det.x      = s_axis_tdata[15:0];
  assign det.y      = s_axis_tdata[31:16];
  assign det.left   = s_axis_tdata[43:32];
  assign det.top    = s_axis_tdata[55:44];
  assign det.width  = s_axis_tdata[67:56];
  assign det.height = s_axis_tdata[79:68];

  cntm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cntm_dpath #(
    .MAX_TRACKS     (MAX_TRACKS),
    .MAX_DETECTIONS (MAX_DETECTIONS),
    .LIFETIME_CAP   (LIFETIME_CAP)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .det_i       (det),
    .area_i      (s_axis_tdata[103:80]),
    .min_area_i  (min_area_q),
    .thr2_i      (thr2_q),
    .lost_lim_i  (cntm_pkg::eff_lost(lost_q)),
    .m_ready_i   (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_trk_o   (out_trk),
    .out_last_o  (out_last),
    .out_ovf_o   (out_ovf)
  );

  assign m_axis_tdata = {16'b0, out_trk.lost, out_trk.life, out_trk.height, out_trk.width,
                         out_trk.top, out_trk.left, out_trk.y, out_trk.x, out_trk.id};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_ovf;

endmodule

/* verif/centroid_nearest_track_matcher_checker.sv */
module centroid_nearest_track_matcher_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         det_valid_i,
  input  logic         det_ready_i,
  input  logic [103:0] det_data_i,
  input  logic         det_last_i,
  input  logic         trk_valid_i,
  input  logic         trk_ready_i,
  input  logic [135:0] trk_data_i,
  input  logic         trk_last_i,
  input  logic [0:0]   trk_user_i,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumTrk = 32;
  localparam int unsigned NumDet = 32;
  localparam int unsigned LifeCap = 10;

  typedef struct packed {
    logic           last;
    logic           ovf;
    cntm_pkg::trk_t trk;
  } track_word_t;

  logic [7:0]  thr_reg;
  logic [3:0]  lost_reg;
  logic [15:0] area_reg;

  cntm_pkg::trk_t tracks [NumTrk];
  int unsigned    num_tracks;
  cntm_pkg::det_t dets [NumDet];
  int unsigned    num_dets;
  logic [31:0]    next_track_id;
  logic           dropped;
  track_word_t    expected_tracks [$];
  int unsigned    fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_tracks.size();

  function automatic logic [33:0] sq(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // Greedy matching over one frame; the track table stays compacted in creation order.
  task automatic close_frame();
    cntm_pkg::trk_t upd [NumTrk];
    logic           claimed [NumDet];
    int unsigned    n;
    logic [7:0]     t;
    logic [3:0]     lim;
    logic [63:0]    thr2, best, d2;
    int             pick;
    track_word_t    w;
    n = 0;
    t = (thr_reg == 0) ? 8'd50 : thr_reg;
    if (t < 10) t = 10;
    if (t > 150) t = 150;
    lim = (lost_reg == 0) ? 4'd5 : lost_reg;
    if (lim > 10) lim = 10;
    thr2 = (64'(t) * 16) * (64'(t) * 16);
    for (int i = 0; i < NumDet; i++) claimed[i] = 1'b0;
    for (int k = 0; k < num_tracks; k++) begin
      best = thr2;
      pick = -1;
      for (int i = 0; i < num_dets; i++) begin
        if (claimed[i]) continue;
        d2 = 64'(sq(tracks[k].x, dets[i].x)) + 64'(sq(tracks[k].y, dets[i].y));
        if (d2 < best) begin
          best = d2;
          pick = i;
        end
      end
      if (pick >= 0) begin
        claimed[pick] = 1'b1;
        upd[n] = tracks[k];
        {upd[n].x, upd[n].y, upd[n].left, upd[n].top, upd[n].width, upd[n].height} = dets[pick];
        if (upd[n].life < LifeCap) upd[n].life++;
        upd[n].lost = '0;
        n++;
      end else if (tracks[k].lost < lim) begin
        upd[n] = tracks[k];
        upd[n].life = '0;
        upd[n].lost = tracks[k].lost + 4'd1;
        n++;
      end
    end
    for (int i = 0; i < num_dets; i++) begin
      if (claimed[i]) continue;
      if (n >= NumTrk) begin
        dropped = 1'b1;
        continue;
      end
      upd[n].id = next_track_id;
      next_track_id++;
      {upd[n].x, upd[n].y, upd[n].left, upd[n].top, upd[n].width, upd[n].height} = dets[i];
      upd[n].life = '0;
      upd[n].lost = '0;
      n++;
    end
    for (int k = 0; k < n; k++) begin
      tracks[k] = upd[k];
      w.trk = upd[k];
      w.last = (k + 1 == n);
      w.ovf = dropped;
      expected_tracks.push_back(w);
    end
    num_tracks = n;
    num_dets = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    track_word_t    exp_w, got;
    cntm_pkg::det_t d;
    logic [23:0]    a;
    if (!rst_ni) begin
      thr_reg = 8'd50;
      lost_reg = 4'd5;
      area_reg = 16'd25;
      num_tracks = 0;
      num_dets = 0;
      next_track_id = '0;
      dropped = 1'b0;
      expected_tracks.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cntm_pkg::reg_idx_e'(cfg_addr_i))
          cntm_pkg::REG_DIST_THR: thr_reg = cfg_data_i[7:0];
          cntm_pkg::REG_MAX_LOST: lost_reg = cfg_data_i[3:0];
          cntm_pkg::REG_MIN_AREA: area_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (trk_valid_i && trk_ready_i) begin
        got.trk = {trk_data_i[31:0], trk_data_i[47:32], trk_data_i[63:48], trk_data_i[75:64],
                   trk_data_i[87:76], trk_data_i[99:88], trk_data_i[111:100],
                   trk_data_i[115:112], trk_data_i[119:116]};
        got.last = trk_last_i;
        got.ovf = trk_user_i[0];
        if (expected_tracks.size() == 0) begin
          fails++;
          $display("%0t: unexpected track word, expected none, actual %h", $time, got);
        end else begin
          exp_w = expected_tracks.pop_front();
          if (got !== exp_w) begin
            fails++;
            $display({"%0t: track mismatch expected id %0d x %h y %h box %h %h %h %h",
                      " life %0d lost %0d last %b ovf %b"},
                     $time, exp_w.trk.id, exp_w.trk.x, exp_w.trk.y, exp_w.trk.left,
                     exp_w.trk.top, exp_w.trk.width, exp_w.trk.height, exp_w.trk.life,
                     exp_w.trk.lost, exp_w.last, exp_w.ovf);
            $display({"%0t: track mismatch actual   id %0d x %h y %h box %h %h %h %h",
                      " life %0d lost %0d last %b ovf %b"},
                     $time, got.trk.id, got.trk.x, got.trk.y, got.trk.left,
                     got.trk.top, got.trk.width, got.trk.height, got.trk.life,
                     got.trk.lost, got.last, got.ovf);
          end
        end
      end
      if (det_valid_i && det_ready_i) begin
        d = {det_data_i[15:0], det_data_i[31:16], det_data_i[43:32], det_data_i[55:44],
             det_data_i[67:56], det_data_i[79:68]};
        a = det_data_i[103:80];
        if (a != 0 && a >= area_reg) begin
          if (num_dets < NumDet) begin
            dets[num_dets] = d;
            num_dets++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (det_last_i) close_frame();
      end
    end
  end
endmodule

/* verif/centroid_nearest_track_matcher_tb.sv */
module centroid_nearest_track_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_addr_i = '0;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [0:0]   m_axis_tuser;
  int unsigned  fail_count;
  int unsigned  pending;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  centroid_nearest_track_matcher dut (.*);

  centroid_nearest_track_matcher_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_addr_i, .cfg_data_i,
    .det_valid_i(s_axis_tvalid), .det_ready_i(s_axis_tready), .det_data_i(s_axis_tdata),
    .det_last_i(s_axis_tlast), .trk_valid_i(m_axis_tvalid), .trk_ready_i(m_axis_tready),
    .trk_data_i(m_axis_tdata), .trk_last_i(m_axis_tlast), .trk_user_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending));

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input cntm_pkg::reg_idx_e idx, input logic [15:0] val);
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drains outstanding tracks, then lets the block settle before a register write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // The word stays valid after acceptance so that the next one can follow at once.
  task automatic send_det(input logic [15:0] x, input logic [15:0] y,
                          input logic [47:0] box, input logic [23:0] area, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {area, box[47:36], box[35:24], box[23:12], box[11:0], y, x};
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Random frame: detections mostly clustered near an anchor so tracks persist and match.
  task automatic random_frame(input int unsigned n);
    logic [15:0] bx, by;
    bx = 16'($urandom_range(200, 65000));
    by = 16'($urandom_range(200, 65000));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_det(16'($urandom), 16'($urandom), 48'({$urandom, $urandom}), 24'($urandom),
                 i == n - 1);
      else
        send_det(16'(bx + $urandom_range(0, 3000) - 1500 + i * 97),
                 16'(by + $urandom_range(0, 3000) - 1500), 48'({$urandom, $urandom}),
                 ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 40)) : 24'($urandom),
                 i == n - 1);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: extremes, zero area, threshold edges, then an overflowing frame.
    send_det(16'h0000, 16'h0000, '0, 24'd0, 1'b0);
    send_det(16'h0000, 16'h0000, '0, 24'd25, 1'b0);
    send_det(16'hFFFF, 16'hFFFF, '1, 24'hFFFFFF, 1'b0);
    send_det(16'd24, 16'd0, 48'h123456789ABC, 24'd24, 1'b1);
    send_det(16'd799, 16'd0, '1, 24'd100, 1'b0);
    send_det(16'hFFFF - 16'd800, 16'hFFFF, '0, 24'd100, 1'b1);
    send_det(16'd5000, 16'd5000, 48'hFFF000FFF000, 24'd30, 1'b1);
    wait_idle();
    write_reg(cntm_pkg::REG_DIST_THR, 16'd0);
    write_reg(cntm_pkg::REG_MAX_LOST, 16'd0);
    write_reg(cntm_pkg::REG_MIN_AREA, 16'd0);
    for (int i = 0; i < 36; i++)
      send_det(16'(i * 1200), 16'(i * 1700), 48'({$urandom, $urandom}), 24'(i), i == 35);
    wait_idle();
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      write_reg(cntm_pkg::REG_DIST_THR, ph == 0 ? 16'd10 : ph == 1 ? 16'd150 :
                ph == 2 ? 16'd5 : ph == 3 ? 16'd255 : 16'($urandom_range(10, 150)));
      write_reg(cntm_pkg::REG_MAX_LOST, ph == 0 ? 16'd1 : ph == 1 ? 16'd10 :
                ph == 2 ? 16'd15 : 16'($urandom_range(1, 10)));
      write_reg(cntm_pkg::REG_MIN_AREA, ph == 0 ? 16'd0 : ph == 1 ? 16'hFFFF :
                16'($urandom_range(0, 2000)));
      for (int f = 0; f < 5; f++) begin
        random_frame($urandom_range(1, 10));
      end
    end
    wait_idle();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) $display("centroid_nearest_track_matcher_tb passed");
    else $display("centroid_nearest_track_matcher_tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("centroid_nearest_track_matcher_tb failed");
    $finish;
  end
endmodule
